[rtl/baro_pkg.sv]
package baro_pkg;

  localparam int RAW_W  = 24;
  localparam int COEF_W = 16;
  localparam int DT_W   = 25;
  localparam int PROD_W = 42;
  localparam int WIDE_W = 40;
  localparam int X_W    = 18;
  localparam int TRAW_W = 19;
  localparam int SQ_W   = 35;
  localparam int TEMP_W = 15;
  localparam int PRES_W = 17;
  localparam int PF_W   = 64;
  localparam int DIFF_W = 44;
  localparam int PRAW_W = 29;
  localparam int CIDX_W = 3;

  localparam logic signed [TRAW_W-1:0] TEMP_REF   = 19'sd2000;
  localparam logic signed [TRAW_W-1:0] TEMP_LOW2  = 19'sd3500;
  localparam logic signed [X_W-1:0]    X_LOW2     = -18'sd3500;
  localparam logic signed [TRAW_W-1:0] TEMP_MIN   = -19'sd4000;
  localparam logic signed [TRAW_W-1:0] TEMP_MAX   = 19'sd8500;
  localparam logic signed [PRAW_W-1:0] PRES_MIN   = 29'sd1000;
  localparam logic signed [PRAW_W-1:0] PRES_MAX   = 29'sd120000;

  typedef enum logic [CIDX_W-1:0] {
    CFG_C1 = 3'd0,
    CFG_C2 = 3'd1,
    CFG_C3 = 3'd2,
    CFG_C4 = 3'd3,
    CFG_C5 = 3'd4,
    CFG_C6 = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic                     flag;
    logic signed [TEMP_W-1:0] temp;
  } temp_res_t;

endpackage

[rtl/baro_pressure_temp_compensation_unit.sv]
// Throughput: one item per cycle through a fixed 10-stage pipeline; busy stays low.
// The receiver cannot stall, so every stage advances on every clock.
// Reset (rst_n low, synchronous) clears the valid bits and all six coefficients.
module baro_pressure_temp_compensation_unit
  import baro_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [RAW_W-1:0]         in_pressure_raw,
  input  logic [RAW_W-1:0]         in_temperature_raw,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CIDX_W-1:0]        cfg_index,
  input  logic [COEF_W-1:0]        cfg_data,
  output logic                     out_valid,
  output logic signed [TEMP_W-1:0] out_temperature_centideg,
  output logic [PRES_W-1:0]        out_pressure_pa,
  output logic                     out_out_of_range
);

  localparam int NV = 9;
  localparam int ND = 6;
  localparam int NT = 6;

  logic [COEF_W-1:0] c1_r, c2_r, c3_r, c4_r, c5_r, c6_r;

  logic [NV-1:0]             vld_r;
  logic [RAW_W-1:0]          d1_pipe_r [ND];
  temp_res_t                 t_pipe_r  [NT];

  logic signed [DT_W-1:0]    dt_r, dt_nxt;
  logic signed [PROD_W-1:0]  p3_r, p4_r, p6_r;
  logic signed [PROD_W-1:0]  p3_sh, p4_sh, p6_sh;
  logic signed [WIDE_W-1:0]  off_r, sens_r, off_nxt, sens_nxt;
  logic signed [X_W-1:0]     x_r;
  logic signed [WIDE_W-1:0]  off4_r, sens4_r;
  logic [SQ_W-1:0]           sq1_r, sq2_r;
  logic signed [2*X_W-1:0]   sq1_full;
  logic signed [TRAW_W-1:0]  e2;
  logic signed [2*TRAW_W-1:0] sq2_full;
  logic                      lt1_r, lt2_r;
  logic signed [TRAW_W-1:0]  temp_full;
  temp_res_t                 tres_nxt;
  logic signed [WIDE_W-1:0]  off5_r, sens5_r;
  logic [WIDE_W-1:0]         off2_r, sens2_r, off2_nxt, sens2_nxt;
  logic [WIDE_W-1:0]         s1, s2;
  logic signed [WIDE_W-1:0]  offf_r, sensf_r;
  logic signed [WIDE_W-1:0]  offf_d1_r, offf_d2_r;
  logic signed [PF_W-1:0]    prod;
  logic signed [PF_W-1:0]    q;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PRAW_W-1:0]  pres_r, pres_nxt;
  logic [PRES_W-1:0]         pres_out_nxt;
  logic                      pflag_nxt;

  logic                      out_valid_r;
  logic signed [TEMP_W-1:0]  out_temp_r;
  logic [PRES_W-1:0]         out_pres_r;
  logic                      out_flag_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
      c5_r <= '0;
      c6_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_C1: c1_r <= cfg_data;
        CFG_C2: c2_r <= cfg_data;
        CFG_C3: c3_r <= cfg_data;
        CFG_C4: c4_r <= cfg_data;
        CFG_C5: c5_r <= cfg_data;
        CFG_C6: c6_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[NV-2:0], start & ~busy};
      out_valid_r <= vld_r[NV-1];
    end
  end

  always_comb begin
    dt_nxt = $signed({1'b0, in_temperature_raw}) - $signed({1'b0, c5_r, 8'h00});

    p3_sh    = p3_r >>> 8;
    p4_sh    = p4_r >>> 7;
    p6_sh    = p6_r >>> 23;
    off_nxt  = $signed({8'h00, c2_r, 16'h0000}) + $signed(p4_sh[WIDE_W-1:0]);
    sens_nxt = $signed({9'h000, c1_r, 15'h0000}) + $signed(p3_sh[WIDE_W-1:0]);

    sq1_full  = $signed({{X_W{x_r[X_W-1]}}, x_r}) * $signed({{X_W{x_r[X_W-1]}}, x_r});
    e2        = $signed({x_r[X_W-1], x_r}) + TEMP_LOW2;
    sq2_full  = $signed({{TRAW_W{e2[TRAW_W-1]}}, e2}) * $signed({{TRAW_W{e2[TRAW_W-1]}}, e2});
    temp_full = $signed({x_r[X_W-1], x_r}) + TEMP_REF;
    if (temp_full < TEMP_MIN) begin
      tres_nxt = '{flag: 1'b1, temp: TEMP_MIN[TEMP_W-1:0]};
    end else if (temp_full > TEMP_MAX) begin
      tres_nxt = '{flag: 1'b1, temp: TEMP_MAX[TEMP_W-1:0]};
    end else begin
      tres_nxt = '{flag: 1'b0, temp: temp_full[TEMP_W-1:0]};
    end

    s1 = {{(WIDE_W-SQ_W){1'b0}}, sq1_r};
    s2 = {{(WIDE_W-SQ_W){1'b0}}, sq2_r};
    off2_nxt  = '0;
    sens2_nxt = '0;
    if (lt1_r) begin
      off2_nxt  = ((s1 << 2) + s1) >> 1;
      sens2_nxt = ((s1 << 2) + s1) >> 2;
      if (lt2_r) begin
        off2_nxt  = off2_nxt + ((s2 << 3) - s2);
        sens2_nxt = sens2_nxt + (((s2 << 3) + (s2 << 1) + s2) >> 1);
      end
    end

    q        = prod >>> 21;
    diff     = $signed(q[DIFF_W-1:0]) - $signed({{(DIFF_W-WIDE_W){offf_d2_r[WIDE_W-1]}},
                                                 offf_d2_r});
    pres_nxt = $signed(diff[DIFF_W-1:15]);

    if (pres_r < PRES_MIN) begin
      pres_out_nxt = PRES_MIN[PRES_W-1:0];
      pflag_nxt    = 1'b1;
    end else if (pres_r > PRES_MAX) begin
      pres_out_nxt = PRES_MAX[PRES_W-1:0];
      pflag_nxt    = 1'b1;
    end else begin
      pres_out_nxt = pres_r[PRES_W-1:0];
      pflag_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    dt_r         <= dt_nxt;
    d1_pipe_r[0] <= in_pressure_raw;
    for (int i = 1; i < ND; i++) begin
      d1_pipe_r[i] <= d1_pipe_r[i-1];
    end

    p3_r <= PROD_W'($signed({1'b0, c3_r})) * PROD_W'(dt_r);
    p4_r <= PROD_W'($signed({1'b0, c4_r})) * PROD_W'(dt_r);
    p6_r <= PROD_W'($signed({1'b0, c6_r})) * PROD_W'(dt_r);

    off_r  <= off_nxt;
    sens_r <= sens_nxt;
    x_r    <= $signed(p6_sh[X_W-1:0]);

    sq1_r       <= sq1_full[SQ_W-1:0];
    sq2_r       <= sq2_full[SQ_W-1:0];
    lt1_r       <= x_r[X_W-1];
    lt2_r       <= x_r < X_LOW2;
    off4_r      <= off_r;
    sens4_r     <= sens_r;
    t_pipe_r[0] <= tres_nxt;
    for (int i = 1; i < NT; i++) begin
      t_pipe_r[i] <= t_pipe_r[i-1];
    end

    off2_r  <= off2_nxt;
    sens2_r <= sens2_nxt;
    off5_r  <= off4_r;
    sens5_r <= sens4_r;

    offf_r  <= off5_r - $signed(off2_r);
    sensf_r <= sens5_r - $signed(sens2_r);

    offf_d1_r <= offf_r;
    offf_d2_r <= offf_d1_r;

    pres_r <= pres_nxt;

    out_temp_r <= t_pipe_r[NT-1].temp;
    out_pres_r <= pres_out_nxt;
    out_flag_r <= t_pipe_r[NT-1].flag | pflag_nxt;
  end

  baro_sens_mul u_sens_mul (
    .clk (clk),
    .a   (d1_pipe_r[ND-1]),
    .b   (sensf_r),
    .p   (prod)
  );

  assign out_valid                = out_valid_r;
  assign out_temperature_centideg = out_temp_r;
  assign out_pressure_pa          = out_pres_r;
  assign out_out_of_range         = out_flag_r;

endmodule

[rtl/baro_sens_mul.sv]
module baro_sens_mul
  import baro_pkg::*;
(
  input  logic                     clk,
  input  logic [RAW_W-1:0]         a,
  input  logic signed [WIDE_W-1:0] b,
  output logic signed [PF_W-1:0]   p
);

  localparam int HALF_W = WIDE_W / 2;
  localparam int PL_W   = RAW_W + HALF_W;
  localparam int PH_W   = PL_W + 1;

  logic [RAW_W+HALF_W-1:0]        pl_r;
  logic signed [RAW_W+HALF_W:0]   ph_r;
  logic signed [PF_W-1:0]         p_r;
  logic signed [PF_W-1:0]         p_nxt;
  logic signed [PF_W-1:0]         hi_ext;

  always_comb begin
    hi_ext = $signed({ph_r[PF_W-HALF_W-1:0], {HALF_W{1'b0}}});
    p_nxt  = hi_ext + $signed({{(PF_W-RAW_W-HALF_W){1'b0}}, pl_r});
  end

  always_ff @(posedge clk) begin
    pl_r <= PL_W'(a) * PL_W'(b[HALF_W-1:0]);
    ph_r <= PH_W'($signed({1'b0, a})) * PH_W'($signed(b[WIDE_W-1:HALF_W]));
    p_r  <= p_nxt;
  end

  assign p = p_r;

endmodule
